// ===== hw/rtl/utrf_pkg.sv =====
// ----------------------------------------------------------------------------
// utrf_pkg: shared definitions for the serial port ring buffer pair
// Ring depths, derived widths, event codes and the control structures that
// pass between the ring controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package utrf_pkg;

    // Ring depths and the widths that follow from them.
    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_LVL_W = $clog2(TX_DEPTH + 1);
    localparam int RX_LVL_W = $clog2(RX_DEPTH + 1);

    // Width of the fill and peak result fields.
    localparam int FILL_W = 7;
    localparam int BYTE_W = 8;

    // Event codes carried by cmd.
    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_RXBYTE = 2'd2;
    localparam logic [1:0] CMD_TXDONE = 2'd3;

    // Result flags and counts of one event, held until the beat is taken.
    typedef struct packed {
        logic              send_valid;
        logic              send_from_ram;
        logic              read_valid;
        logic              dropped;
        logic [FILL_W-1:0] tx_fill;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] rx_peak;
    } utrf_res_t;

    // Memory commands and result of the event being accepted.
    typedef struct packed {
        logic                tx_we;
        logic                tx_re;
        logic [TX_PTR_W-1:0] tx_addr;
        logic                rx_we;
        logic                rx_re;
        logic [RX_PTR_W-1:0] rx_addr;
        utrf_res_t           res;
    } utrf_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utrf_ram.sv =====
// ----------------------------------------------------------------------------
// utrf_ram: generic single-port synchronous RAM
// One access per cycle, write or read; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module utrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/utrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// utrf_ctrl: ring pointer and fill controller
// Decodes each event, keeps read and write pointers, fill levels and the
// receive high-water mark, and issues the ring memory accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module utrf_ctrl
    import utrf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [1:0] cmd,
    input  wire logic       tx_idle,
    output utrf_ctrl_t      ctrl
);

    logic [TX_PTR_W-1:0] tx_rptr_reg, tx_rptr_next;
    logic [TX_PTR_W-1:0] tx_wptr_reg, tx_wptr_next;
    logic [TX_LVL_W-1:0] tx_level_reg, tx_level_next;
    logic [RX_PTR_W-1:0] rx_rptr_reg, rx_rptr_next;
    logic [RX_PTR_W-1:0] rx_wptr_reg, rx_wptr_next;
    logic [RX_LVL_W-1:0] rx_level_reg, rx_level_next;
    logic [RX_LVL_W-1:0] rx_peak_reg, rx_peak_next;

    // Event decode: next pointers, levels and memory commands.
    always_comb
    begin
        tx_rptr_next  = tx_rptr_reg;
        tx_wptr_next  = tx_wptr_reg;
        tx_level_next = tx_level_reg;
        rx_rptr_next  = rx_rptr_reg;
        rx_wptr_next  = rx_wptr_reg;
        rx_level_next = rx_level_reg;
        rx_peak_next  = rx_peak_reg;
        ctrl          = '0;

        case (cmd)
            CMD_PUT:
            begin
                if (tx_idle && (tx_level_reg == '0))
                begin
                    ctrl.res.send_valid = 1'b1;
                end
                else if (tx_level_reg != TX_LVL_W'(TX_DEPTH))
                begin
                    ctrl.tx_we    = accept;
                    tx_wptr_next  = (tx_wptr_reg == TX_PTR_W'(TX_DEPTH - 1)) ?
                                    '0 : tx_wptr_reg + 1'b1;
                    tx_level_next = tx_level_reg + 1'b1;
                end
                else
                begin
                    ctrl.res.dropped = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (rx_level_reg != '0)
                begin
                    ctrl.rx_re          = accept;
                    ctrl.res.read_valid = 1'b1;
                    rx_rptr_next  = (rx_rptr_reg == RX_PTR_W'(RX_DEPTH - 1)) ?
                                    '0 : rx_rptr_reg + 1'b1;
                    rx_level_next = rx_level_reg - 1'b1;
                end
            end
            CMD_RXBYTE:
            begin
                if (rx_level_reg != RX_LVL_W'(RX_DEPTH))
                begin
                    ctrl.rx_we    = accept;
                    rx_wptr_next  = (rx_wptr_reg == RX_PTR_W'(RX_DEPTH - 1)) ?
                                    '0 : rx_wptr_reg + 1'b1;
                    rx_level_next = rx_level_reg + 1'b1;
                    if (rx_level_next > rx_peak_reg)
                    begin
                        rx_peak_next = rx_level_next;
                    end
                end
                else
                begin
                    ctrl.res.dropped = 1'b1;
                end
            end
            default:
            begin
                // Transmit complete: pop the next queued byte, if any.
                if (tx_level_reg != '0)
                begin
                    ctrl.tx_re             = accept;
                    ctrl.res.send_valid    = 1'b1;
                    ctrl.res.send_from_ram = 1'b1;
                    tx_rptr_next  = (tx_rptr_reg == TX_PTR_W'(TX_DEPTH - 1)) ?
                                    '0 : tx_rptr_reg + 1'b1;
                    tx_level_next = tx_level_reg - 1'b1;
                end
            end
        endcase

        ctrl.tx_addr     = ctrl.tx_we ? tx_wptr_reg : tx_rptr_reg;
        ctrl.rx_addr     = ctrl.rx_we ? rx_wptr_reg : rx_rptr_reg;
        ctrl.res.tx_fill = FILL_W'(tx_level_next);
        ctrl.res.rx_fill = FILL_W'(rx_level_next);
        ctrl.res.rx_peak = FILL_W'(rx_peak_next);
    end

    // Pointer and level registers advance only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_rptr_reg  <= '0;
            tx_wptr_reg  <= '0;
            tx_level_reg <= '0;
            rx_rptr_reg  <= '0;
            rx_wptr_reg  <= '0;
            rx_level_reg <= '0;
            rx_peak_reg  <= '0;
        end
        else if (accept)
        begin
            tx_rptr_reg  <= tx_rptr_next;
            tx_wptr_reg  <= tx_wptr_next;
            tx_level_reg <= tx_level_next;
            rx_rptr_reg  <= rx_rptr_next;
            rx_wptr_reg  <= rx_wptr_next;
            rx_level_reg <= rx_level_next;
            rx_peak_reg  <= rx_peak_next;
        end
    end

`ifndef SYNTHESIS
    // An empty ring has its pointers together.
    a_tx_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_level_reg == '0) |-> (tx_rptr_reg == tx_wptr_reg))
        else $error("transmit ring empty with pointers apart");
    a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_level_reg == '0) |-> (rx_rptr_reg == rx_wptr_reg))
        else $error("receive ring empty with pointers apart");
    // The transmit level stays within the ring depth.
    a_tx_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        tx_level_reg <= TX_LVL_W'(TX_DEPTH))
        else $error("transmit level above depth");
    // The high-water mark never falls below the current receive fill.
    a_rx_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rx_peak_reg >= rx_level_reg)
        else $error("receive peak below receive level");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/uart_tx_rx_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_fifo: transmit and receive byte rings for a serial port
// Applies one put, get, receive or transmit-complete event per beat and
// returns one result beat with the fills of both rings.
// ----------------------------------------------------------------------------
// The block returns the result of each event in the cycle after the event is
// accepted, the time the ring memories need for their registered read. The
// result waits in an output register; a new event is taken in the same cycle
// as the waiting result is taken, so with out_ready held high the rate is one
// event per cycle. Each ring is one single-port memory touched at most once
// per event, so no access ever collides. Memory contents are not cleared at
// reset; only entries already written are read.
`default_nettype none

module uart_tx_rx_ring_fifo
    import utrf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        cmd,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              tx_idle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   send_valid,
    output logic      [BYTE_W-1:0] send_byte,
    output logic                   read_valid,
    output logic      [BYTE_W-1:0] read_byte,
    output logic                   dropped,
    output logic      [FILL_W-1:0] tx_fill,
    output logic      [FILL_W-1:0] rx_fill,
    output logic      [FILL_W-1:0] rx_peak
);

    utrf_ctrl_t        ctrl;
    utrf_res_t         res_reg;
    logic [BYTE_W-1:0] direct_byte_reg;
    logic              out_valid_reg;
    logic              accept;
    logic [BYTE_W-1:0] tx_rdata;
    logic [BYTE_W-1:0] rx_rdata;

    // Input is taken when the result slot is free or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    utrf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .tx_idle (tx_idle),
        .ctrl    (ctrl)
    );

    utrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (ctrl.tx_we),
        .re    (ctrl.tx_re),
        .addr  (ctrl.tx_addr),
        .wdata (data_byte),
        .rdata (tx_rdata)
    );

    utrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (ctrl.rx_we),
        .re    (ctrl.rx_re),
        .addr  (ctrl.rx_addr),
        .wdata (data_byte),
        .rdata (rx_rdata)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, captured with the accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg         <= ctrl.res;
            direct_byte_reg <= data_byte;
        end
    end

    // Output fields; popped bytes come straight from the memory read register.
    assign out_valid  = out_valid_reg;
    assign send_valid = res_reg.send_valid;
    assign send_byte  = !res_reg.send_valid   ? '0 :
                        res_reg.send_from_ram ? tx_rdata : direct_byte_reg;
    assign read_valid = res_reg.read_valid;
    assign read_byte  = res_reg.read_valid ? rx_rdata : '0;
    assign dropped    = res_reg.dropped;
    assign tx_fill    = res_reg.tx_fill;
    assign rx_fill    = res_reg.rx_fill;
    assign rx_peak    = res_reg.rx_peak;

endmodule

`default_nettype wire
